/* sv/bts_pkg.sv */
// Shared types, codes and texel conversion functions for the bilinear texture sampler.
// No dependencies; imported by the sampler.
`timescale 1ns / 1ps

package bts_pkg;

    // Command codes
    typedef enum logic [1:0] {
        CMD_RAW    = 2'd0,
        CMD_PIXEL  = 2'd1,
        CMD_FETCH  = 2'd2,
        CMD_SAMPLE = 2'd3
    } cmd_t;

    // Pixel format codes (codes 2 and 3 behave as half float)
    localparam logic [1:0] FMT_R8    = 2'd0;
    localparam logic [1:0] FMT_RGBA8 = 2'd1;

    // Register indexes
    localparam logic [1:0] REG_BASE_W = 2'd0;
    localparam logic [1:0] REG_BASE_H = 2'd1;
    localparam logic [1:0] REG_FORMAT = 2'd2;

    localparam int APB_AW = 4;

    // Four Q23.16 channels, channel 0 in the low slot
    typedef logic [3:0][39:0] quad_t;

    // Unorm byte to Q16: round(n * 65536 / 255) = n * 257 + (n >= 128)
    function automatic logic [39:0] unorm_q16(input logic [7:0] n);
        return {24'd0, n, n} + 40'(n[7]);
    endfunction

    // Half float to Q23.16, round half away from zero, saturating infinities
    function automatic logic [39:0] half_q16(input logic [15:0] h);
        logic [4:0]  e;
        logic [10:0] m;
        logic [39:0] mag;
        int          s;
        e = h[14:10];
        m = {(e != 5'd0), h[9:0]};
        if (e == 5'h1f)
        begin
            if (h[9:0] != 10'd0)
                return '0;
            return h[15] ? 40'h80_0000_0000 : 40'h7F_FFFF_FFFF;
        end
        s = ((e != 5'd0) ? int'(e) : 1) - 9;
        if (s >= 0)
            mag = 40'(m) << s;
        else
            mag = (40'(m) + (40'd1 << (-s - 1))) >> (-s);
        return h[15] ? (40'd0 - mag) : mag;
    endfunction

    // Decode a stored texel into four channels
    function automatic quad_t conv_texel(input logic [63:0] t, input logic [1:0] fmt);
        quad_t q;
        q = '0;
        if (fmt == FMT_R8)
        begin
            q[0] = unorm_q16(t[7:0]);
        end
        else if (fmt == FMT_RGBA8)
        begin
            for (int i = 0; i < 4; i++)
                q[i] = unorm_q16(t[8*i +: 8]);
        end
        else
        begin
            for (int i = 0; i < 4; i++)
                q[i] = half_q16(t[16*i +: 16]);
        end
        return q;
    endfunction

    // Q1.16 value clamped to 0..1, scaled to a byte by truncation
    function automatic logic [7:0] to_byte(input logic [17:0] v);
        logic [16:0] c;
        logic [24:0] p;
        if (v[17])
            c = '0;
        else if (v[16:0] > 17'd65536)
            c = 17'd65536;
        else
            c = v[16:0];
        p = {c, 8'd0} - 25'(c);
        return p[23:16];
    endfunction

    // floor((a*(1-f) + b*f + 0.5)) in Q16, written as a + floor(((b-a)*f + 0.5))
    function automatic logic [39:0] blend(input logic [39:0] a, input logic [39:0] b,
                                          input logic [15:0] f);
        logic signed [40:0] d;
        logic signed [57:0] p;
        logic signed [57:0] s;
        d = $signed({b[39], b}) - $signed({a[39], a});
        p = d * $signed({1'b0, f});
        s = p + 58'sd32768;
        return a + s[55:16];
    endfunction

endpackage

/* sv/bts_if.sv */
// Request and result channel interfaces of the bilinear texture sampler.
// Depends on bts_pkg for nothing but shares its field widths by convention.
`timescale 1ns / 1ps

interface bts_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [7:0]  x;
    logic signed [7:0]  y;
    logic [2:0]         level;
    logic               layer;
    logic [63:0]        raw_texel;
    logic signed [19:0] u;
    logic signed [19:0] v;
    logic signed [17:0] in_r;
    logic signed [17:0] in_g;
    logic signed [17:0] in_b;
    logic signed [17:0] in_a;

    modport source (output valid, cmd, x, y, level, layer, raw_texel, u, v,
                    in_r, in_g, in_b, in_a, input ready);
    modport sink (input valid, cmd, x, y, level, layer, raw_texel, u, v,
                  in_r, in_g, in_b, in_a, output ready);
endinterface

interface bts_res_if;
    logic               valid;
    logic               ready;
    logic signed [39:0] out_r;
    logic signed [39:0] out_g;
    logic signed [39:0] out_b;
    logic signed [39:0] out_a;
    logic               error;

    modport source (output valid, out_r, out_g, out_b, out_a, error, input ready);
    modport sink (input valid, out_r, out_g, out_b, out_a, error, output ready);
endinterface

/* sv/bts_texel_mem.sv */
// Single-port texel memory with registered read data.
// Standalone; instantiated by bilinear_texture_sampler.
`timescale 1ns / 1ps

module bts_texel_mem #(
    parameter longint unsigned DEPTH = 57344,
    parameter int              AW    = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [63:0]   wdata,
    output logic [63:0]   rdata
);

    logic [63:0] mem [DEPTH];
    logic [63:0] rdata_reg;

    // Write, or read into the registered read data
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        else
            rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/bilinear_texture_sampler.sv */
// Writes pass through S_MUL, S_COORD and S_WR; fetches and bilinear samples through S_MUL,
// S_COORD and S_RD0..S_RD4, S_BLT, S_BLB, S_BLF (four reads of the single-port texel memory,
// then three blend steps of the four channel lanes). Both end in S_DONE, which waits for a free
// output register. One request at a time: the next is taken once the sampler is back in S_IDLE,
// while a finished result may still wait in the output register. rst_n clears control and
// configuration at once; the texel memory is not cleared and holds unknown data until written.
`timescale 1ns / 1ps

module bilinear_texture_sampler
    import bts_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int LEVELS     = 7,
    parameter int LAYERS     = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    bts_req_if.sink           req,
    bts_res_if.source         res
);

    localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int LVW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int LYW   = (LAYERS > 1) ? $clog2(LAYERS) : 1;
    localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int EXT_W = $clog2(MAXD + 1);
    localparam longint unsigned DEPTH =
        longint'(LAYERS) * longint'(LEVELS) * longint'(MAX_HEIGHT) * longint'(MAX_WIDTH);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = 25 + EXT_W;
    localparam int IXW   = CW - 16;
    localparam int IXW1  = IXW + 1;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_MUL   = 13'b0000000000010,
        S_COORD = 13'b0000000000100,
        S_WR    = 13'b0000000001000,
        S_RD0   = 13'b0000000010000,
        S_RD1   = 13'b0000000100000,
        S_RD2   = 13'b0000001000000,
        S_RD3   = 13'b0000010000000,
        S_RD4   = 13'b0000100000000,
        S_BLT   = 13'b0001000000000,
        S_BLB   = 13'b0010000000000,
        S_BLF   = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } state_t;

    // Level extent: base clamped to 1..maxv, shifted by level, at least 1
    function automatic logic [EXT_W-1:0] extent(input logic [6:0] base, input int maxv,
                                                 input logic [LVW-1:0] lv);
        logic [EXT_W-1:0] b;
        logic [EXT_W-1:0] s;
        if (base == 7'd0)
            b = EXT_W'(1);
        else if (int'(base) > maxv)
            b = EXT_W'(maxv);
        else
            b = EXT_W'(base);
        s = b >> lv;
        if (s == '0)
            s = EXT_W'(1);
        return s;
    endfunction

    // Clamp to edge: 0..e-1
    function automatic logic [EXT_W-1:0] clamp_c(input logic signed [IXW:0] v,
                                                 input logic [EXT_W-1:0] e);
        logic signed [IXW:0] es;
        es = IXW1'({1'b0, e});
        if (v < 0)
            return '0;
        if (v >= es)
            return EXT_W'(e - 1'b1);
        return v[EXT_W-1:0];
    endfunction

    state_t state_reg, state_next;

    logic [6:0] base_w_reg, base_h_reg;
    logic [1:0] fmt_reg;

    logic [1:0]             cmd_reg;
    logic signed [7:0]      x_reg, y_reg;
    logic [LVW-1:0]         lvl_reg;
    logic [LYW-1:0]         lay_reg;
    logic [EXT_W-1:0]       w_reg, h_reg;
    logic signed [19:0]     u_reg, v_reg;
    logic [63:0]            wdata_reg;
    logic                   err_reg;
    logic signed [CW-1:0]   cu_reg, cv_reg;
    logic [XW-1:0]          x0_reg, x1_reg;
    logic [YW-1:0]          y0_reg, y1_reg;
    logic [15:0]            fx_reg, fy_reg;
    quad_t                  p00_reg, p10_reg, p01_reg, p11_reg;
    quad_t                  top_reg, bot_reg, blr_reg;

    logic                   res_valid_reg;
    quad_t                  res_q_reg;
    logic                   res_err_reg;

    logic                   acc;
    logic                   out_free;
    logic [LVW-1:0]         lvl_c;
    logic [LYW-1:0]         lay_c;
    logic [63:0]            wdata_c;
    logic                   is_sample;
    logic signed [IXW-1:0]  bx, by;
    logic signed [IXW:0]    bx_e, by_e;
    logic [XW-1:0]          xs;
    logic [YW-1:0]          ys;
    logic [AW-1:0]          mem_addr;
    logic                   mem_we;
    logic [63:0]            mem_rdata;
    quad_t                  texel_q;
    quad_t                  bl_a, bl_b, bl_y;
    logic [15:0]            bl_f;

    // Configuration port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_w_reg <= 7'd64;
            base_h_reg <= 7'd64;
            fmt_reg    <= FMT_RGBA8;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_BASE_W: base_w_reg <= pwdata[6:0];
                REG_BASE_H: base_h_reg <= pwdata[6:0];
                REG_FORMAT: fmt_reg    <= pwdata[1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_BASE_W: prdata = {25'd0, base_w_reg};
            REG_BASE_H: prdata = {25'd0, base_h_reg};
            REG_FORMAT: prdata = {30'd0, fmt_reg};
            default:    prdata = '0;
        endcase
    end

    // Request intake
    assign req.ready = (state_reg == S_IDLE);
    assign acc       = req.valid && req.ready;

    assign lvl_c = (int'(req.level) > LEVELS - 1) ? LVW'(LEVELS - 1) : LVW'(req.level);
    assign lay_c = (int'(req.layer) > LAYERS - 1) ? LYW'(LAYERS - 1) : LYW'(req.layer);

    always_comb
    begin
        if (req.cmd == CMD_RAW)
            wdata_c = req.raw_texel;
        else if (fmt_reg == FMT_R8)
            wdata_c = {56'd0, to_byte(req.in_r)};
        else
            wdata_c = {32'd0, to_byte(req.in_a), to_byte(req.in_b),
                       to_byte(req.in_g), to_byte(req.in_r)};
    end

    // Coordinate setup
    assign is_sample = (cmd_reg == CMD_SAMPLE);
    assign bx   = is_sample ? $signed(cu_reg[CW-1:16]) : IXW'(x_reg);
    assign by   = is_sample ? $signed(cv_reg[CW-1:16]) : IXW'(y_reg);
    assign bx_e = {bx[IXW-1], bx};
    assign by_e = {by[IXW-1], by};

    // Memory address: surface, row, column
    assign xs = (state_reg == S_RD1 || state_reg == S_RD3) ? x1_reg : x0_reg;
    assign ys = (state_reg == S_RD2 || state_reg == S_RD3) ? y1_reg : y0_reg;
    assign mem_addr = (((AW'(lay_reg) * AW'(LEVELS) + AW'(lvl_reg)) * AW'(MAX_HEIGHT)
                       + AW'(ys)) * AW'(MAX_WIDTH)) + AW'(xs);
    assign mem_we = (state_reg == S_WR) && !err_reg;

    bts_texel_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (wdata_reg),
        .rdata (mem_rdata)
    );

    assign texel_q = conv_texel(mem_rdata, fmt_reg);

    // Shared blend lanes
    always_comb
    begin
        case (state_reg)
            S_BLT:
            begin
                bl_a = p00_reg;
                bl_b = p10_reg;
                bl_f = fx_reg;
            end
            S_BLB:
            begin
                bl_a = p01_reg;
                bl_b = p11_reg;
                bl_f = fx_reg;
            end
            default:
            begin
                bl_a = top_reg;
                bl_b = bot_reg;
                bl_f = fy_reg;
            end
        endcase
        for (int i = 0; i < 4; i++)
            bl_y[i] = blend(bl_a[i], bl_b[i], bl_f);
    end

    assign out_free = !res_valid_reg || res.ready;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (acc) state_next = S_MUL;
            S_MUL:   state_next = S_COORD;
            S_COORD: state_next = cmd_reg[1] ? S_RD0 : S_WR;
            S_WR:    state_next = S_DONE;
            S_RD0:   state_next = S_RD1;
            S_RD1:   state_next = S_RD2;
            S_RD2:   state_next = S_RD3;
            S_RD3:   state_next = S_RD4;
            S_RD4:   state_next = S_BLT;
            S_BLT:   state_next = S_BLB;
            S_BLB:   state_next = S_BLF;
            S_BLF:   state_next = S_DONE;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DONE && out_free)
                res_valid_reg <= 1'b1;
            else if (res.ready)
                res_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                cmd_reg   <= req.cmd;
                x_reg     <= req.x;
                y_reg     <= req.y;
                lvl_reg   <= lvl_c;
                lay_reg   <= lay_c;
                w_reg     <= extent(base_w_reg, MAX_WIDTH, lvl_c);
                h_reg     <= extent(base_h_reg, MAX_HEIGHT, lvl_c);
                u_reg     <= req.u;
                v_reg     <= req.v;
                wdata_reg <= wdata_c;
                err_reg   <= (req.cmd == CMD_PIXEL) && fmt_reg[1];
            end
            S_MUL:
            begin
                cu_reg <= CW'(u_reg) * $signed(CW'({1'b0, w_reg})) - CW'(32768);
                cv_reg <= CW'(v_reg) * $signed(CW'({1'b0, h_reg})) - CW'(32768);
            end
            S_COORD:
            begin
                x0_reg <= XW'(clamp_c(bx_e, w_reg));
                y0_reg <= YW'(clamp_c(by_e, h_reg));
                x1_reg <= is_sample ? XW'(clamp_c(bx_e + IXW1'(1), w_reg))
                                    : XW'(clamp_c(bx_e, w_reg));
                y1_reg <= is_sample ? YW'(clamp_c(by_e + IXW1'(1), h_reg))
                                    : YW'(clamp_c(by_e, h_reg));
                fx_reg <= is_sample ? cu_reg[15:0] : 16'd0;
                fy_reg <= is_sample ? cv_reg[15:0] : 16'd0;
            end
            S_RD1:   p00_reg <= texel_q;
            S_RD2:   p10_reg <= texel_q;
            S_RD3:   p01_reg <= texel_q;
            S_RD4:   p11_reg <= texel_q;
            S_BLT:   top_reg <= bl_y;
            S_BLB:   bot_reg <= bl_y;
            S_BLF:   blr_reg <= bl_y;
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && out_free)
        begin
            res_q_reg   <= cmd_reg[1] ? blr_reg : '0;
            res_err_reg <= err_reg;
        end
    end

    assign res.valid = res_valid_reg;
    assign res.out_r = res_q_reg[0];
    assign res.out_g = res_q_reg[1];
    assign res.out_b = res_q_reg[2];
    assign res.out_a = res_q_reg[3];
    assign res.error = res_err_reg;

endmodule

/* sv/bts_checker.sv */
// Port-level checks of the bilinear texture sampler, bound to its top level.
// Depends on bilinear_texture_sampler and its request/result interfaces.
`timescale 1ns / 1ps

module bts_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic        res_error,
    input logic [39:0] res_r,
    input logic [39:0] res_g,
    input logic [39:0] res_b,
    input logic [39:0] res_a,
    input logic        pready
);

    logic [2:0] pend_reg;
    logic [2:0] pend_next;

    // Requests accepted but not yet delivered
    always_comb
    begin
        pend_next = pend_reg;
        if (req_valid && req_ready)
            pend_next = pend_next + 3'd1;
        if (res_valid && res_ready)
            pend_next = pend_next - 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 3'd0;
        else
            pend_reg <= pend_next;
    end

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped before it was taken");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> pend_reg != 3'd0)
        else $error("result without an outstanding request");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 3'd2)
        else $error("more requests in flight than the sampler can hold");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_error |-> res_r == 40'd0 && res_g == 40'd0
                                   && res_b == 40'd0 && res_a == 40'd0)
        else $error("failed pixel write returned color data");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("configuration port stalled");

endmodule

bind bilinear_texture_sampler bts_checker u_bts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_error (res.error),
    .res_r     (res.out_r),
    .res_g     (res.out_g),
    .res_b     (res.out_b),
    .res_a     (res.out_a),
    .pready    (pready)
);
